// ----- design/rsd_pkg.sv -----
// shared types, constants and fixed-point helpers for the ray-sphere shader
`timescale 1ns / 1ps

package rsd_pkg;

  typedef struct packed {
    logic [10:0] pixel_col;
    logic [9:0]  pixel_row;
  } rsd_in_t;

  typedef struct packed {
    logic [7:0] shade;
    logic       hit;
  } rsd_out_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_X  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_Y  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_Z  = 3'd6;

  localparam logic signed [31:0] RST_OFFSET_X = -32'sd327680;
  localparam logic signed [31:0] RST_OFFSET_Y = -32'sd327680;
  localparam logic signed [31:0] RST_OFFSET_Z = 32'sd786432;
  localparam logic [30:0]        RST_RADIUS   = 31'd131072;
  localparam logic signed [17:0] RST_LIGHT_X  = 18'sd0;
  localparam logic signed [17:0] RST_LIGHT_Y  = 18'sd65536;
  localparam logic signed [17:0] RST_LIGHT_Z  = 18'sd0;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // ray direction reciprocal width
  localparam int RCP_W = 30;
  localparam int DIR_W = 27;

  // square root: 24 result bits, two per stage
  localparam int SQ_PER = 2;
  localparam int SQ_STG = 12;
  localparam int ROOT_W = SQ_PER * SQ_STG;

  // divider: 48 quotient bits, three per stage, plus output register
  localparam int DIV_PER = 3;
  localparam int DIV_STG = 16;
  localparam int DIV_LAT = DIV_STG + 1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // product of two q16.16 values back to q16.16, floor and saturate
  function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
    return sat32(p >>> 16);
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

endpackage

// ----- design/rsd_delay.sv -----
// enabled shift line that carries side data along a pipelined unit
`timescale 1ns / 1ps

module rsd_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) tap_r[i] <= '0;
    end else if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// ----- design/rsd_sqrt.sv -----
// pipelined q16.16 square root, two result bits per stage
`timescale 1ns / 1ps

module rsd_sqrt import rsd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x,
  output logic [ROOT_W-1:0]  root
);

  logic [27:0]       rem_r   [SQ_STG];
  logic [ROOT_W-1:0] root_r  [SQ_STG];
  logic [47:0]       v_r     [SQ_STG];
  logic [27:0]       rem_nxt [SQ_STG];
  logic [ROOT_W-1:0] root_nxt[SQ_STG];
  logic [47:0]       v_nxt   [SQ_STG];

  always_comb begin
    logic [27:0]       rem;
    logic [27:0]       trial;
    logic [ROOT_W-1:0] rt;
    logic [47:0]       vv;
    for (int s = 0; s < SQ_STG; s++) begin
      if (s == 0) begin
        rem = '0;
        rt  = '0;
        // non-positive input gives zero
        vv  = (!x[31] && (x != 32'sd0)) ? {1'b0, x[30:0], 16'h0000} : 48'h0;
      end else begin
        rem = rem_r[s-1];
        rt  = root_r[s-1];
        vv  = v_r[s-1];
      end
      for (int k = 0; k < SQ_PER; k++) begin
        rem   = {rem[25:0], vv[47:46]};
        trial = {2'b00, rt, 2'b01};
        if (rem >= trial) begin
          rem = rem - trial;
          rt  = {rt[ROOT_W-2:0], 1'b1};
        end else begin
          rt  = {rt[ROOT_W-2:0], 1'b0};
        end
        vv = {vv[45:0], 2'b00};
      end
      rem_nxt[s]  = rem;
      root_nxt[s] = rt;
      v_nxt[s]    = vv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQ_STG; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        v_r[s]    <= v_nxt[s];
      end
    end
  end

  assign root = root_r[SQ_STG-1];

endmodule

// ----- design/rsd_div.sv -----
// pipelined saturating q16.16 divide, truncating toward zero
`timescale 1ns / 1ps

module rsd_div import rsd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  output logic signed [31:0] quo
);

  logic [31:0] rem_r  [DIV_STG];
  logic [47:0] w_r    [DIV_STG];
  logic [31:0] den_r  [DIV_STG];
  logic        neg_r  [DIV_STG];
  logic [31:0] rem_nxt[DIV_STG];
  logic [47:0] w_nxt  [DIV_STG];
  logic [31:0] den_nxt[DIV_STG];
  logic        neg_nxt[DIV_STG];
  logic signed [31:0] quo_r;
  logic signed [31:0] quo_nxt;

  always_comb begin
    logic [31:0] rem;
    logic [47:0] w;
    logic [31:0] dv;
    logic        ng;
    logic [32:0] sh;
    logic [31:0] mag;
    for (int s = 0; s < DIV_STG; s++) begin
      if (s == 0) begin
        mag = num[31] ? (~num + 32'd1) : num;
        rem = '0;
        w   = {mag, 16'h0000};
        dv  = den;
        ng  = num[31];
      end else begin
        rem = rem_r[s-1];
        w   = w_r[s-1];
        dv  = den_r[s-1];
        ng  = neg_r[s-1];
      end
      // dividend bits leave at the top, quotient bits enter at the bottom
      for (int k = 0; k < DIV_PER; k++) begin
        sh = {rem, w[47]};
        if (sh >= {1'b0, dv}) begin
          sh = sh - {1'b0, dv};
          w  = {w[46:0], 1'b1};
        end else begin
          w  = {w[46:0], 1'b0};
        end
        rem = sh[31:0];
      end
      rem_nxt[s] = rem;
      w_nxt[s]   = w;
      den_nxt[s] = dv;
      neg_nxt[s] = ng;
    end
  end

  always_comb begin
    logic [47:0] q;
    q = w_r[DIV_STG-1];
    if (den_r[DIV_STG-1] == 32'd0) quo_nxt = 32'sd0;
    else if (neg_r[DIV_STG-1]) begin
      quo_nxt = (q > 48'h0000_8000_0000) ? 32'sh8000_0000 : (~q[31:0] + 32'd1);
    end else begin
      quo_nxt = (q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STG; s++) begin
        rem_r[s] <= rem_nxt[s];
        w_r[s]   <= w_nxt[s];
        den_r[s] <= den_nxt[s];
        neg_r[s] <= neg_nxt[s];
      end
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

// ----- design/ray_sphere_diffuse_shader.sv -----
// ray-sphere intersection with lambert shading, top level
// One pixel per clock while the output is not held off: a new transfer is
// taken every cycle. Two 12-stage square-root units, each followed by its
// dividers, lie in series with the multiply and add stages. The whole
// pipeline advances together; when the output transfer is held off, the
// input is held off in the same cycle and nothing is lost. The user must
// write configuration registers through the cfg port only while the pipeline
// is empty; the block does not enforce it. Later stages read them directly.
`timescale 1ns / 1ps

module ray_sphere_diffuse_shader import rsd_pkg::*; #(
  parameter int IMAGE_WIDTH  = 1200,
  parameter int IMAGE_HEIGHT = 800
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rsd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rsd_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // exact floor(n * 2^16 / d) through a ceiling reciprocal
  localparam int COL_SH = 28 + $clog2(IMAGE_WIDTH);
  localparam int ROW_SH = 28 + $clog2(IMAGE_HEIGHT - 1);
  localparam logic [63:0] COL_RCP =
    ((64'd1 << COL_SH) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH);
  localparam logic [63:0] ROW_RCP =
    ((64'd1 << ROW_SH) + 64'(IMAGE_HEIGHT - 1) - 64'd1) / 64'(IMAGE_HEIGHT - 1);
  localparam int PRD_W = 11 + RCP_W;

  typedef struct packed {
    logic               v;
    logic               miss;
    logic signed [31:0] a;
    logic signed [31:0] h;
    logic [DIR_W-1:0]   dx;
    logic [DIR_W-1:0]   dy;
  } rsd_sq1_t;

  typedef struct packed {
    logic             v;
    logic             miss;
    logic [DIR_W-1:0] dx;
    logic [DIR_W-1:0] dy;
  } rsd_dv1_t;

  typedef struct packed {
    logic               v;
    logic               miss;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
  } rsd_sq2_t;

  typedef struct packed {
    logic v;
    logic miss;
    logic zero;
  } rsd_dv2_t;

  logic adv;

  // configuration
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic [30:0]        rad_r;
  logic signed [17:0] lx_r, ly_r, lz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r  <= RST_OFFSET_X;
      oy_r  <= RST_OFFSET_Y;
      oz_r  <= RST_OFFSET_Z;
      rad_r <= RST_RADIUS;
      lx_r  <= RST_LIGHT_X;
      ly_r  <= RST_LIGHT_Y;
      lz_r  <= RST_LIGHT_Z;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OFFSET_X: ox_r  <= cfg_wdata;
        CFG_OFFSET_Y: oy_r  <= cfg_wdata;
        CFG_OFFSET_Z: oz_r  <= cfg_wdata;
        CFG_RADIUS:   rad_r <= cfg_wdata[30:0];
        CFG_LIGHT_X:  lx_r  <= cfg_wdata[17:0];
        CFG_LIGHT_Y:  ly_r  <= cfg_wdata[17:0];
        CFG_LIGHT_Z:  lz_r  <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage registers
  logic             v1_r;
  logic [PRD_W-1:0] px1_r, py1_r;

  logic               v2_r;
  logic [DIR_W-1:0]   dx2_r, dy2_r;
  logic signed [63:0] paax2_r, paay2_r, phx2_r, phy2_r;
  logic signed [63:0] pcx2_r, pcy2_r, pcz2_r, prr2_r;

  logic               v3_r;
  logic [DIR_W-1:0]   dx3_r, dy3_r;
  logic signed [31:0] a3_r, h3_r, c3_r;

  logic               v4_r;
  logic [DIR_W-1:0]   dx4_r, dy4_r;
  logic signed [31:0] a4_r, h4_r;
  logic signed [63:0] phh4_r, pac4_r;

  logic               v5_r;
  logic [DIR_W-1:0]   dx5_r, dy5_r;
  logic signed [31:0] a5_r, h5_r, disc5_r;

  logic               v6_r, miss6_r;
  logic [DIR_W-1:0]   dx6_r, dy6_r;
  logic signed [31:0] a6_r, num6_r;

  logic               v7_r, miss7_r;
  logic signed [63:0] ptx7_r, pty7_r;
  logic signed [31:0] t7_r;

  logic               v8_r, miss8_r;
  logic signed [31:0] nx8_r, ny8_r, nz8_r;

  logic               v9_r, miss9_r;
  logic signed [31:0] nx9_r, ny9_r, nz9_r;
  logic signed [63:0] pnx9_r, pny9_r, pnz9_r;

  logic               v10_r, miss10_r;
  logic signed [31:0] nx10_r, ny10_r, nz10_r, nn10_r;

  logic               v12_r, miss12_r, zero12_r;
  logic signed [63:0] plx12_r, ply12_r, plz12_r;

  logic               v13_r, miss13_r, zero13_r;
  logic signed [31:0] cos13_r;

  logic     out_valid_r;
  rsd_out_t out_data_r;

  // unit connections
  logic [ROOT_W-1:0]  root1, root2;
  logic signed [31:0] t_q, ux_q, uy_q, uz_q;
  rsd_sq1_t           sq1_d, sq1_q;
  rsd_dv1_t           dv1_d, dv1_q;
  rsd_sq2_t           sq2_d, sq2_q;
  rsd_dv2_t           dv2_d, dv2_q;
  rsd_out_t           out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0; v10_r <= 1'b0;
      v12_r <= 1'b0; v13_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= sq1_q.v;
      v7_r        <= dv1_q.v;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      v10_r       <= v9_r;
      v12_r       <= dv2_q.v;
      v13_r       <= v12_r;
      out_valid_r <= v13_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // ray direction
      px1_r <= PRD_W'(in_data.pixel_col) * PRD_W'(COL_RCP[RCP_W-1:0]);
      py1_r <= PRD_W'(in_data.pixel_row) * PRD_W'(ROW_RCP[RCP_W-1:0]);

      // quadratic terms
      dx2_r   <= DIR_W'(px1_r >> (COL_SH - 16));
      dy2_r   <= DIR_W'(py1_r >> (ROW_SH - 16));
      paax2_r <= $signed({1'b0, DIR_W'(px1_r >> (COL_SH - 16))})
               * $signed({1'b0, DIR_W'(px1_r >> (COL_SH - 16))});
      paay2_r <= $signed({1'b0, DIR_W'(py1_r >> (ROW_SH - 16))})
               * $signed({1'b0, DIR_W'(py1_r >> (ROW_SH - 16))});
      phx2_r  <= ox_r * $signed({1'b0, DIR_W'(px1_r >> (COL_SH - 16))});
      phy2_r  <= oy_r * $signed({1'b0, DIR_W'(py1_r >> (ROW_SH - 16))});
      pcx2_r  <= ox_r * ox_r;
      pcy2_r  <= oy_r * oy_r;
      pcz2_r  <= oz_r * oz_r;
      prr2_r  <= $signed({1'b0, rad_r}) * $signed({1'b0, rad_r});

      // dz is -1, so dz*dz is one and oz*dz is -oz
      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
      a3_r  <= sadd(sadd(qfix(paax2_r), qfix(paay2_r)), Q_ONE);
      h3_r  <= sadd(sadd(qfix(phx2_r), qfix(phy2_r)), ssub(32'sd0, oz_r));
      c3_r  <= ssub(sadd(sadd(qfix(pcx2_r), qfix(pcy2_r)), qfix(pcz2_r)),
                    qfix(prr2_r));

      dx4_r  <= dx3_r;
      dy4_r  <= dy3_r;
      a4_r   <= a3_r;
      h4_r   <= h3_r;
      phh4_r <= h3_r * h3_r;
      pac4_r <= a3_r * c3_r;

      dx5_r   <= dx4_r;
      dy5_r   <= dy4_r;
      a5_r    <= a4_r;
      h5_r    <= h4_r;
      disc5_r <= ssub(qfix(phh4_r), qfix(pac4_r));

      // nearer root numerator
      miss6_r <= sq1_q.miss;
      dx6_r   <= sq1_q.dx;
      dy6_r   <= sq1_q.dy;
      a6_r    <= sq1_q.a;
      num6_r  <= ssub(ssub(32'sd0, sq1_q.h), 32'(root1));

      miss7_r <= dv1_q.miss;
      ptx7_r  <= t_q * $signed({1'b0, dv1_q.dx});
      pty7_r  <= t_q * $signed({1'b0, dv1_q.dy});
      t7_r    <= t_q;

      // normal
      miss8_r <= miss7_r;
      nx8_r   <= sadd(ox_r, qfix(ptx7_r));
      ny8_r   <= sadd(oy_r, qfix(pty7_r));
      nz8_r   <= sadd(oz_r, ssub(32'sd0, t7_r));

      miss9_r <= miss8_r;
      nx9_r   <= nx8_r;
      ny9_r   <= ny8_r;
      nz9_r   <= nz8_r;
      pnx9_r  <= nx8_r * nx8_r;
      pny9_r  <= ny8_r * ny8_r;
      pnz9_r  <= nz8_r * nz8_r;

      miss10_r <= miss9_r;
      nx10_r   <= nx9_r;
      ny10_r   <= ny9_r;
      nz10_r   <= nz9_r;
      nn10_r   <= sadd(sadd(qfix(pnx9_r), qfix(pny9_r)), qfix(pnz9_r));

      // lambert term
      miss12_r <= dv2_q.miss;
      zero12_r <= dv2_q.zero;
      plx12_r  <= ux_q * lx_r;
      ply12_r  <= uy_q * ly_r;
      plz12_r  <= uz_q * lz_r;

      miss13_r <= miss12_r;
      zero13_r <= zero12_r;
      cos13_r  <= sadd(sadd(qfix(plx12_r), qfix(ply12_r)), qfix(plz12_r));

      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    logic [39:0] scaled;
    scaled = (40'(cos13_r) << 8) - 40'(cos13_r);
    out_nxt.hit = !miss13_r;
    if (miss13_r) out_nxt.shade = 8'hFF;
    else if (zero13_r || cos13_r[31] || (cos13_r == 32'sd0)) out_nxt.shade = 8'h00;
    else if (scaled[39:16] > 24'd255) out_nxt.shade = 8'hFF;
    else out_nxt.shade = scaled[23:16];
  end

  // first square root and divide: t = (-h - sqrt(disc)) / a
  assign sq1_d = '{v: v5_r, miss: disc5_r[31], a: a5_r, h: h5_r, dx: dx5_r, dy: dy5_r};

  rsd_sqrt u_sqrt_disc (.clk(clk), .en(adv), .x(disc5_r), .root(root1));

  rsd_delay #(.W($bits(rsd_sq1_t)), .DEPTH(SQ_STG)) u_dly_sq1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(sq1_d), .q(sq1_q)
  );

  assign dv1_d = '{v: v6_r, miss: miss6_r, dx: dx6_r, dy: dy6_r};

  rsd_div u_div_t (.clk(clk), .en(adv), .num(num6_r), .den(a6_r), .quo(t_q));

  rsd_delay #(.W($bits(rsd_dv1_t)), .DEPTH(DIV_LAT)) u_dly_dv1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(dv1_d), .q(dv1_q)
  );

  // normal length and normalization
  assign sq2_d = '{v: v10_r, miss: miss10_r, nx: nx10_r, ny: ny10_r, nz: nz10_r};

  rsd_sqrt u_sqrt_len (.clk(clk), .en(adv), .x(nn10_r), .root(root2));

  rsd_delay #(.W($bits(rsd_sq2_t)), .DEPTH(SQ_STG)) u_dly_sq2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(sq2_d), .q(sq2_q)
  );

  assign dv2_d = '{v: sq2_q.v, miss: sq2_q.miss, zero: (root2 == '0)};

  rsd_div u_div_ux (.clk(clk), .en(adv), .num(sq2_q.nx), .den(32'(root2)), .quo(ux_q));
  rsd_div u_div_uy (.clk(clk), .en(adv), .num(sq2_q.ny), .den(32'(root2)), .quo(uy_q));
  rsd_div u_div_uz (.clk(clk), .en(adv), .num(sq2_q.nz), .den(32'(root2)), .quo(uz_q));

  rsd_delay #(.W($bits(rsd_dv2_t)), .DEPTH(DIV_LAT)) u_dly_dv2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(dv2_d), .q(dv2_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a missed ray always shows white
  a_miss_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.shade == 8'hFF))
    else $error("miss without white shade");

  // a held result must hold the input side too
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // an empty output never blocks the input
  a_empty_takes_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule
